// File: hw/rtl/run_length_offset_table_unit_macros.svh
// Assertion macros shared by the RTL of the run-length offset table unit.
`ifndef RUN_LENGTH_OFFSET_TABLE_UNIT_MACROS_SVH
`define RUN_LENGTH_OFFSET_TABLE_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RLOT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define RLOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rlot_pkg.sv
`default_nettype none

package rlot_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

   // Command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_APPEND = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] sample_number;
      logic [31:0] run_length;
      logic [31:0] entry_offset;
   } req_type;

   typedef struct packed {
      logic [31:0] offset_out;
      status_type  status;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/run_length_offset_table_unit.sv
// Channel   Ports                  Handshake
// request   req_data               accepted when start is high and busy is low
// response  rsp_data, rsp_strobe   strobe marks each item, high for a single cycle
//
// Append and a lookup of sample zero answer in the cycle after the accept
// edge and keep busy low. Other lookups hold busy high and walk the runs from
// the cached run (or run 0), answering on a hit, or with a range status when
// the walk runs off the end; each run is one table read and one 33-bit compare.
// Synchronous reset clears the run count, the cache and the sequencer; no
// clearing pass. The receiver cannot stall, so a response never waits.
`default_nettype none

`include "run_length_offset_table_unit_macros.svh"

module run_length_offset_table_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  rlot_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output rlot_pkg::rsp_type   rsp_data
);

   // Run table: {run_length, offset} per entry
   logic [63:0] table_mem [rlot_pkg::MAX_ENTRIES];

   rlot_pkg::state_type          state_ff, state_in;
   logic [rlot_pkg::CNT_W-1:0]   entry_total_ff, entry_total_in;
   logic [31:0]                  cache_start_ff, cache_start_in;
   logic [rlot_pkg::IDX_W-1:0]   cache_idx_ff, cache_idx_in;
   logic [rlot_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [31:0]                  walk_start_ff, walk_start_in;
   logic [31:0]                  sample_ff, sample_in;
   logic [63:0]                  rd_data_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   rlot_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        wr_en;
   logic [32:0] run_end;
   logic        hit;
   logic        at_end;

   assign accept  = start && (state_ff == rlot_pkg::ST_IDLE);
   assign run_end = {1'b0, walk_start_ff} + {1'b0, rd_data_ff[63:32]};
   assign hit     = {1'b0, sample_ff} <= run_end;
   assign at_end  = idx_ff >= entry_total_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlot_pkg::ST_IDLE: begin
            if (accept && (req_data.cmd == rlot_pkg::CMD_LOOKUP)
                && (req_data.sample_number != 32'd0)) begin
               state_in = rlot_pkg::ST_FETCH;
            end
         end
         rlot_pkg::ST_FETCH: begin
            state_in = at_end ? rlot_pkg::ST_IDLE : rlot_pkg::ST_CHECK;
         end
         rlot_pkg::ST_CHECK: begin
            state_in = hit ? rlot_pkg::ST_IDLE : rlot_pkg::ST_FETCH;
         end
         default: state_in = rlot_pkg::ST_IDLE;
      endcase
   end

   // Datapath and response
   always_comb begin
      entry_total_in = entry_total_ff;
      cache_start_in = cache_start_ff;
      cache_idx_in   = cache_idx_ff;
      idx_in         = idx_ff;
      walk_start_in  = walk_start_ff;
      sample_in      = sample_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;
      case (state_ff)
         rlot_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_data.sample_number;
               if (req_data.cmd == rlot_pkg::CMD_APPEND) begin
                  // append at the end, or refuse when full
                  rsp_strobe_in          = 1'b1;
                  rsp_data_in.offset_out = 32'd0;
                  if (entry_total_ff == rlot_pkg::MAX_COUNT) begin
                     rsp_data_in.status = rlot_pkg::STATUS_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     entry_total_in     = entry_total_ff + 1'b1;
                     rsp_data_in.status = rlot_pkg::STATUS_OK;
                  end
               end else if (req_data.sample_number == 32'd0) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_data_in.offset_out = 32'd0;
                  rsp_data_in.status     = rlot_pkg::STATUS_RANGE;
               end else if (req_data.sample_number >= cache_start_ff) begin
                  // walk on from the cached run
                  idx_in        = {1'b0, cache_idx_ff};
                  walk_start_in = cache_start_ff;
               end else begin
                  idx_in        = '0;
                  walk_start_in = 32'd0;
               end
            end
         end
         rlot_pkg::ST_FETCH: begin
            if (at_end) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.offset_out = 32'd0;
               rsp_data_in.status     = rlot_pkg::STATUS_RANGE;
            end
         end
         rlot_pkg::ST_CHECK: begin
            if (hit) begin
               cache_idx_in           = idx_ff[rlot_pkg::IDX_W-1:0];
               cache_start_in         = walk_start_ff;
               rsp_strobe_in          = 1'b1;
               rsp_data_in.offset_out = rd_data_ff[31:0];
               rsp_data_in.status     = rlot_pkg::STATUS_OK;
            end else begin
               // no match: the sum stays below the sample, so 32 bits hold it
               walk_start_in = run_end[31:0];
               idx_in        = idx_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rlot_pkg::ST_IDLE;
         entry_total_ff <= '0;
         cache_start_ff <= 32'd0;
         cache_idx_ff   <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_total_ff <= entry_total_in;
         cache_start_ff <= cache_start_in;
         cache_idx_ff   <= cache_idx_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      walk_start_ff <= walk_start_in;
      sample_ff     <= sample_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Table write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[entry_total_ff[rlot_pkg::IDX_W-1:0]] <=
            {req_data.run_length, req_data.entry_offset};
      end
   end

   // Table read port, registered
   always_ff @(posedge clock) begin
      if (state_ff == rlot_pkg::ST_FETCH) begin
         rd_data_ff <= table_mem[idx_ff[rlot_pkg::IDX_W-1:0]];
      end
   end

   assign busy       = (state_ff != rlot_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `RLOT_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe_ff,
      state_ff == rlot_pkg::ST_IDLE, "response while walking")
   `RLOT_ASSERT_NOW(a_total_bound, clock, reset, 1'b1,
      entry_total_ff <= rlot_pkg::MAX_COUNT, "run count past table size")
   `RLOT_ASSERT_NOW(a_check_in_table, clock, reset, state_ff == rlot_pkg::ST_CHECK,
      idx_ff < entry_total_ff, "compare on run beyond table")
   `RLOT_ASSERT_NEXT(a_full_refused, clock, reset,
      accept && (req_data.cmd == rlot_pkg::CMD_APPEND)
         && (entry_total_ff == rlot_pkg::MAX_COUNT),
      rsp_strobe_ff && (rsp_data_ff.status == rlot_pkg::STATUS_FULL),
      "full append not refused")

endmodule

`default_nettype wire
